// File: sv/sgc_pkg.sv
`default_nettype none
package sgc_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int EXT_BITS   = 23;
  localparam int T_BITS     = 16;

  // Boundary offsets q and slopes p need room for coordinate plus extent
  localparam int Q_BITS   = ((COORD_BITS > EXT_BITS) ? COORD_BITS : EXT_BITS + 1) + 2;
  localparam int D_BITS   = COORD_BITS + 1;
  localparam int QUO_BITS = T_BITS + 2;
  localparam int R_BITS   = T_BITS + 3;
  localparam int CMP_BITS = Q_BITS + T_BITS;
  localparam int P_BITS   = T_BITS + COORD_BITS + 3;
  localparam int LANES    = 4;

  // Boundary lanes, tested in this order
  localparam int LANE_LEFT   = 0;
  localparam int LANE_RIGHT  = 1;
  localparam int LANE_BOTTOM = 2;
  localparam int LANE_TOP    = 3;

  typedef enum logic [0:0] {
    CFG_HALF_WIDTH  = 1'b0,
    CFG_HALF_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [EXT_BITS-1:0] extent_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_in_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } seg_out_t;

  // One boundary on its way through the divider row
  typedef struct packed {
    logic                zero;
    logic                pos;
    logic                nneg;
    logic                sat;
    logic                nsat;
    logic [D_BITS-1:0]   div;
    logic [D_BITS-1:0]   rem;
    logic [QUO_BITS-1:0] dq;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    seg_in_t               seg;
    lane_t [LANES-1:0]     lane;
  } pipe_t;

endpackage
`default_nettype wire

// File: sv/sgc_prep.sv
`default_nettype none
module sgc_prep (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire sgc_pkg::seg_in_t in_data,
  input  wire sgc_pkg::extent_t hw,
  input  wire sgc_pkg::extent_t hh,
  output sgc_pkg::pipe_t        stg_out
);
  import sgc_pkg::*;

  logic    valid_r;
  seg_in_t seg_r;
  lane_t [LANES-1:0] lane_r;
  lane_t [LANES-1:0] lane_nxt;

  // Set up one boundary: divisor |p|, numerator sign and saturation checks
  function automatic lane_t lane_setup(input logic signed [Q_BITS-1:0] p,
                                       input logic signed [Q_BITS-1:0] q);
    lane_t l;
    logic signed [Q_BITS-1:0] n;
    logic [Q_BITS-1:0] mag;
    logic [D_BITS-1:0] dv;
    n   = p[Q_BITS-1] ? -q : q;
    mag = n[Q_BITS-1] ? unsigned'(-n) : unsigned'(n);
    dv  = p[Q_BITS-1] ? D_BITS'(-p) : D_BITS'(p);
    l.zero = (p == '0);
    l.pos  = !p[Q_BITS-1] && (p != '0);
    l.nneg = n[Q_BITS-1];
    l.sat  = CMP_BITS'(mag) >= (CMP_BITS'(dv) << 2);
    l.nsat = (CMP_BITS'(mag) << T_BITS) >= CMP_BITS'(dv);
    l.div  = dv;
    l.rem  = D_BITS'(mag >> 2);
    l.dq   = {mag[1:0], {T_BITS{1'b0}}};
    return l;
  endfunction

  // Form p and q for left, right, bottom, top
  always_comb begin
    logic signed [Q_BITS-1:0] sx, sy, ex, ey, hwq, hhq, dx, dy;
    sx  = Q_BITS'(in_data.start_x);
    sy  = Q_BITS'(in_data.start_y);
    ex  = Q_BITS'(in_data.end_x);
    ey  = Q_BITS'(in_data.end_y);
    hwq = $signed(Q_BITS'(hw));
    hhq = $signed(Q_BITS'(hh));
    dx  = ex - sx;
    dy  = ey - sy;
    lane_nxt[LANE_LEFT]   = lane_setup(-dx, sx + hwq);
    lane_nxt[LANE_RIGHT]  = lane_setup(dx, hwq - sx);
    lane_nxt[LANE_BOTTOM] = lane_setup(-dy, sy + hhq);
    lane_nxt[LANE_TOP]    = lane_setup(dy, hhq - sy);
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg_r  <= in_data;
      lane_r <= lane_nxt;
    end
  end

  assign stg_out = '{valid: valid_r, seg: seg_r, lane: lane_r};

endmodule
`default_nettype wire

// File: sv/sgc_div_cell.sv
`default_nettype none
module sgc_div_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire sgc_pkg::pipe_t stg_in,
  output sgc_pkg::pipe_t      stg_out
);
  import sgc_pkg::*;

  logic    valid_r;
  seg_in_t seg_r;
  lane_t [LANES-1:0] lane_r;
  lane_t [LANES-1:0] lane_nxt;

  // One restoring step per boundary: shift in a bit, subtract if it fits
  always_comb begin
    logic [D_BITS:0] trial;
    logic            qbit;
    lane_nxt = stg_in.lane;
    for (int i = 0; i < LANES; i++) begin
      trial = {stg_in.lane[i].rem, stg_in.lane[i].dq[QUO_BITS-1]};
      qbit  = (trial >= {1'b0, stg_in.lane[i].div});
      if (qbit) begin
        lane_nxt[i].rem = D_BITS'(trial - {1'b0, stg_in.lane[i].div});
      end else begin
        lane_nxt[i].rem = D_BITS'(trial);
      end
      lane_nxt[i].dq = {stg_in.lane[i].dq[QUO_BITS-2:0], qbit};
    end
  end

  // Advance to the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg_r  <= stg_in.seg;
      lane_r <= lane_nxt;
    end
  end

  assign stg_out = '{valid: valid_r, seg: seg_r, lane: lane_r};

endmodule
`default_nettype wire

// File: sv/sgc_tail.sv
`default_nettype none
module sgc_tail (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire sgc_pkg::pipe_t stg_in,
  output logic                out_valid,
  output sgc_pkg::seg_out_t   out_data
);
  import sgc_pkg::*;

  localparam logic signed [R_BITS-1:0] T_ONE    = R_BITS'(1 << T_BITS);
  localparam logic signed [R_BITS-1:0] T_ONE_P1 = R_BITS'((1 << T_BITS) + 1);
  localparam int HALF_T = 1 << (T_BITS - 1);

  // Interval stage
  logic                     a_valid_r, a_ok_r, a_ok_nxt;
  logic [T_BITS:0]          a_t0_r, a_t1_r, a_t0_nxt, a_t1_nxt;
  seg_in_t                  a_seg_r;
  logic signed [D_BITS-1:0] a_dx_r, a_dy_r, a_dx_nxt, a_dy_nxt;

  // Product stage
  logic                     m_valid_r, m_ok_r;
  seg_in_t                  m_seg_r;
  logic signed [P_BITS-1:0] m_sx_r, m_sy_r, m_ex_r, m_ey_r;

  // Output register
  logic     f_valid_r;
  seg_out_t f_out_r, f_out_nxt;
  seg_in_t  f_seg_r;

  // Saturated ratio q/p as a T_BITS fraction
  function automatic logic signed [R_BITS-1:0] lane_ratio(input lane_t l);
    logic signed [R_BITS-1:0] r;
    if (l.nneg) begin
      r = l.nsat ? -R_BITS'(1) : '0;
    end else if (l.sat || ($signed(R_BITS'(l.dq)) > T_ONE_P1)) begin
      r = T_ONE_P1;
    end else begin
      r = $signed(R_BITS'(l.dq));
    end
    return r;
  endfunction

  // start + round(t*d), halves rounded up
  function automatic coord_t lerp(input coord_t a, input logic signed [P_BITS-1:0] pr);
    logic signed [P_BITS:0] s;
    s = $signed({pr[P_BITS-1], pr}) + $signed((P_BITS+1)'(HALF_T));
    return a + COORD_BITS'(s >>> T_BITS);
  endfunction

  // Narrow [t0, t1] over the four boundaries in order
  always_comb begin
    logic signed [R_BITS-1:0] t0, t1, r;
    logic ok;
    t0 = '0;
    t1 = T_ONE;
    ok = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      r = lane_ratio(stg_in.lane[i]);
      if (ok) begin
        if (stg_in.lane[i].zero) begin
          if (stg_in.lane[i].nneg) ok = 1'b0;
        end else if (!stg_in.lane[i].pos) begin
          if (r > t1) ok = 1'b0;
          else if (r > t0) t0 = r;
        end else begin
          if (r < t0) ok = 1'b0;
          else if (r < t1) t1 = r;
        end
      end
    end
    a_ok_nxt = ok;
    a_t0_nxt = (T_BITS+1)'(t0);
    a_t1_nxt = (T_BITS+1)'(t1);
    a_dx_nxt = D_BITS'(stg_in.seg.end_x) - D_BITS'(stg_in.seg.start_x);
    a_dy_nxt = D_BITS'(stg_in.seg.end_y) - D_BITS'(stg_in.seg.start_y);
  end

  // Build the result from the products
  always_comb begin
    f_out_nxt.accepted = m_ok_r;
    if (m_ok_r) begin
      f_out_nxt.clip_start_x = lerp(m_seg_r.start_x, m_sx_r);
      f_out_nxt.clip_start_y = lerp(m_seg_r.start_y, m_sy_r);
      f_out_nxt.clip_end_x   = lerp(m_seg_r.start_x, m_ex_r);
      f_out_nxt.clip_end_y   = lerp(m_seg_r.start_y, m_ey_r);
    end else begin
      f_out_nxt.clip_start_x = m_seg_r.start_x;
      f_out_nxt.clip_start_y = m_seg_r.start_y;
      f_out_nxt.clip_end_x   = m_seg_r.end_x;
      f_out_nxt.clip_end_y   = m_seg_r.end_y;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= stg_in.valid;
      m_valid_r <= a_valid_r;
      f_valid_r <= m_valid_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_ok_r  <= a_ok_nxt;
      a_t0_r  <= a_t0_nxt;
      a_t1_r  <= a_t1_nxt;
      a_seg_r <= stg_in.seg;
      a_dx_r  <= a_dx_nxt;
      a_dy_r  <= a_dy_nxt;
      m_ok_r  <= a_ok_r;
      m_seg_r <= a_seg_r;
      m_sx_r  <= $signed({1'b0, a_t0_r}) * a_dx_r;
      m_sy_r  <= $signed({1'b0, a_t0_r}) * a_dy_r;
      m_ex_r  <= $signed({1'b0, a_t1_r}) * a_dx_r;
      m_ey_r  <= $signed({1'b0, a_t1_r}) * a_dy_r;
      f_out_r <= f_out_nxt;
      f_seg_r <= m_seg_r;
    end
  end

  assign out_valid = f_valid_r;
  assign out_data  = f_out_r;

`ifndef SYNTHESIS
  a_interval_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && a_ok_r |-> a_t0_r <= a_t1_r)
    else $error("clip interval inverted");

  a_start_x_between: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r && f_out_r.accepted |->
      ((f_out_r.clip_start_x >= f_seg_r.start_x) && (f_out_r.clip_start_x <= f_seg_r.end_x)) ||
      ((f_out_r.clip_start_x >= f_seg_r.end_x) && (f_out_r.clip_start_x <= f_seg_r.start_x)))
    else $error("clipped start x outside segment");

  a_end_y_between: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r && f_out_r.accepted |->
      ((f_out_r.clip_end_y >= f_seg_r.start_y) && (f_out_r.clip_end_y <= f_seg_r.end_y)) ||
      ((f_out_r.clip_end_y >= f_seg_r.end_y) && (f_out_r.clip_end_y <= f_seg_r.start_y)))
    else $error("clipped end y outside segment");

  a_reject_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r && !f_out_r.accepted |->
      (f_out_r.clip_start_x == f_seg_r.start_x) && (f_out_r.clip_start_y == f_seg_r.start_y) &&
      (f_out_r.clip_end_x == f_seg_r.end_x) && (f_out_r.clip_end_y == f_seg_r.end_y))
    else $error("rejected segment altered");
`endif

endmodule
`default_nettype wire

// File: sv/segment_rectangle_clipper.sv
`default_nettype none
// Liang-Barsky clipper for one segment against the rectangle |x| <= half_width,
// |y| <= half_height (signed fixed point, t kept as unsigned Q1.16). It takes one
// segment per clock while the output is not stalled and returns one result per
// segment once it has passed one setup stage, a row of 18 divider cells that
// each retire one quotient bit of all four boundary ratios, then the interval,
// multiply and output stages. The whole pipeline holds while a finished result
// is stalled at the output. Write the extents only while no segment is in flight.
module segment_rectangle_clipper (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sgc_pkg::seg_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sgc_pkg::seg_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire sgc_pkg::cfg_idx_t cfg_index,
  input  wire sgc_pkg::extent_t  cfg_wdata
);
  import sgc_pkg::*;

  extent_t hw_r, hh_r;
  logic    adv;
  pipe_t   chain [QUO_BITS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
      hh_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_WIDTH:  hw_r <= cfg_wdata;
        CFG_HALF_HEIGHT: hh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold everything while the output result is stalled
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  sgc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .hw       (hw_r),
    .hh       (hh_r),
    .stg_out  (chain[0])
  );

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
    sgc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stg_in  (chain[k]),
      .stg_out (chain[k+1])
    );
  end

  sgc_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .stg_in    (chain[QUO_BITS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: bench/clip_checker.sv
`default_nettype none
module clip_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire sgc_pkg::seg_in_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire sgc_pkg::seg_out_t out_data,
  input  wire logic              cfg_we,
  input  wire sgc_pkg::cfg_idx_t cfg_index,
  input  wire sgc_pkg::extent_t  cfg_wdata,
  output int                     fail_count,
  output int                     pending
);
  import sgc_pkg::*;

  localparam longint T_ONE = longint'(1) << T_BITS;

  extent_t  half_w;
  extent_t  half_h;
  seg_out_t clip_q[$];

  // t * d / 2^T added to a, rounded to nearest with halves going up
  function automatic longint blend(longint a, longint t, longint d);
    longint bias;
    longint prod;
    bias = longint'(1) << 60;
    prod = t * d + (longint'(1) << (T_BITS - 1)) + bias;
    return a + ((prod >>> T_BITS) - (bias >>> T_BITS));
  endfunction

  // q / p as a fraction of T_ONE, truncated toward zero, saturated to -1 .. T_ONE+1
  function automatic longint edge_ratio(longint q, longint p);
    longint n;
    longint d;
    longint r;
    n = (p < 0) ? -q : q;
    d = (p < 0) ? -p : p;
    if (n >= 0) r = (n * T_ONE) / d;
    else r = -(((-n) * T_ONE) / d);
    if (r < -1) r = -1;
    if (r > T_ONE + 1) r = T_ONE + 1;
    return r;
  endfunction

  function automatic seg_out_t clip_segment(seg_in_t s);
    longint   sx, sy, ex, ey, hw, hh, dx, dy, t0, t1, r;
    longint   p[4];
    longint   q[4];
    bit       ok;
    seg_out_t res;
    sx = s.start_x;
    sy = s.start_y;
    ex = s.end_x;
    ey = s.end_y;
    hw = longint'(half_w);
    hh = longint'(half_h);
    dx = ex - sx;
    dy = ey - sy;
    t0 = 0;
    t1 = T_ONE;
    ok = 1'b1;
    p[LANE_LEFT]   = -dx; q[LANE_LEFT]   = sx + hw;
    p[LANE_RIGHT]  = dx;  q[LANE_RIGHT]  = hw - sx;
    p[LANE_BOTTOM] = -dy; q[LANE_BOTTOM] = sy + hh;
    p[LANE_TOP]    = dy;  q[LANE_TOP]    = hh - sy;
    // narrow the parameter interval boundary by boundary
    for (int i = 0; i < 4; i++) begin
      if (ok) begin
        if (p[i] == 0) begin
          if (q[i] < 0) ok = 1'b0;
        end else begin
          r = edge_ratio(q[i], p[i]);
          if (p[i] < 0) begin
            if (r > t1) ok = 1'b0;
            else if (r > t0) t0 = r;
          end else begin
            if (r < t0) ok = 1'b0;
            else if (r < t1) t1 = r;
          end
        end
      end
    end
    res.accepted = ok;
    if (!ok) begin
      res.clip_start_x = s.start_x;
      res.clip_start_y = s.start_y;
      res.clip_end_x   = s.end_x;
      res.clip_end_y   = s.end_y;
    end else begin
      res.clip_start_x = coord_t'(blend(sx, t0, dx));
      res.clip_start_y = coord_t'(blend(sy, t0, dy));
      res.clip_end_x   = coord_t'(blend(sx, t1, dx));
      res.clip_end_y   = coord_t'(blend(sy, t1, dy));
    end
    return res;
  endfunction

  // track extents, predict each request, compare each result
  always @(posedge clk) begin
    seg_out_t want;
    if (!rst_n) begin
      half_w     <= '0;
      half_h     <= '0;
      fail_count <= 0;
      pending    <= 0;
      clip_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HALF_WIDTH) half_w <= cfg_wdata;
        else half_h <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (clip_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = clip_q.pop_front();
          if (want !== out_data) begin
            fail_count <= fail_count + 1;
            if (want.accepted !== out_data.accepted)
              $error("accepted expected %0d got %0d", want.accepted, out_data.accepted);
            if (want.clip_start_x !== out_data.clip_start_x)
              $error("clip_start_x expected %0d got %0d",
                     want.clip_start_x, out_data.clip_start_x);
            if (want.clip_start_y !== out_data.clip_start_y)
              $error("clip_start_y expected %0d got %0d",
                     want.clip_start_y, out_data.clip_start_y);
            if (want.clip_end_x !== out_data.clip_end_x)
              $error("clip_end_x expected %0d got %0d",
                     want.clip_end_x, out_data.clip_end_x);
            if (want.clip_end_y !== out_data.clip_end_y)
              $error("clip_end_y expected %0d got %0d",
                     want.clip_end_y, out_data.clip_end_y);
          end
        end
      end
      if (in_valid && !in_stall) clip_q.push_back(clip_segment(in_data));
      pending <= clip_q.size();
    end
  end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
module testbench;
  import sgc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN      = 40;
  localparam int CMIN       = -(1 << 23);
  localparam int CMAX       = (1 << 23) - 1;
  localparam int EXT_MAX    = (1 << 23) - 1;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  seg_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  seg_out_t out_data;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  extent_t  cfg_wdata;
  int       fail_count;
  int       pending;
  int       idle_cycles;
  int       stall_mode;
  int       stall_left;
  int       hw_now;
  int       hh_now;

  segment_rectangle_clipper dut (.*);

  clip_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // receiver stall: switch between free flow, light and heavy stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_extent(cfg_idx_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= extent_t'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain the pipeline, then load new extents
  task automatic set_rect(int hw, int hh);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    write_extent(CFG_HALF_WIDTH, hw);
    write_extent(CFG_HALF_HEIGHT, hh);
    hw_now = hw;
    hh_now = hh;
  endtask

  // hold the request until it is taken; valid stays high for the next one
  task automatic send_seg(int sx, int sy, int ex, int ey);
    in_valid <= 1'b1;
    in_data  <= '{coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey)};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic int clamp(longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return int'(v);
  endfunction

  // coordinate near the rectangle along one axis
  function automatic int near_coord(int ext);
    longint e;
    e = longint'(ext) * 2 + 64;
    return clamp(longint'($urandom_range(0, 32'(2 * e))) - e);
  endfunction

  task automatic random_seg();
    int kind;
    int sx, sy, ex, ey;
    kind = $urandom_range(0, 9);
    sx = near_coord(hw_now);
    sy = near_coord(hh_now);
    ex = near_coord(hw_now);
    ey = near_coord(hh_now);
    case (kind)
      0, 1: begin
        sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
      end
      2: begin
        ex = sx; ey = sy;
      end
      3: ex = sx;
      4: ey = sy;
      default: ;
    endcase
    send_seg(sx, sy, ex, ey);
  endtask

  task automatic random_phase(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) random_seg();
      left -= burst;
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
    pause(1);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_HALF_WIDTH;
    cfg_wdata  = '0;
    stall_mode = 0;
    stall_left = 0;
    idle_cycles = 0;
    hw_now     = 0;
    hh_now     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero extents: only the origin survives
    send_seg(0, 0, 0, 0);
    send_seg(1, 0, 1, 0);
    send_seg(-256, -256, 256, 256);
    pause(3);

    set_rect(4096, 2048);
    // fully inside, crossing, outside, parallel and degenerate cases
    send_seg(-100, -50, 200, 70);
    send_seg(-8000, 0, 8000, 0);
    send_seg(0, -5000, 0, 5000);
    send_seg(-8000, -8000, 8000, 8000);
    send_seg(8000, 8000, -8000, -8000);
    send_seg(5000, 0, 5000, 100);
    send_seg(-5000, 0, -5000, 100);
    send_seg(0, 3000, 10, 3000);
    send_seg(0, -3000, 10, -3000);
    send_seg(100, 100, 100, 100);
    send_seg(9000, 100, 9000, 100);
    send_seg(4096, 2048, 4096, 2048);
    send_seg(5000, 5000, 6000, 6000);
    send_seg(CMIN, CMIN, CMAX, CMAX);
    send_seg(CMAX, CMIN, CMIN, CMAX);
    send_seg(CMIN, CMIN, CMIN, CMIN);
    send_seg(CMAX, CMAX, CMAX, CMAX);
    send_seg(-4097, 0, 4097, 1);
    pause(2);

    set_rect(EXT_MAX, EXT_MAX);
    send_seg(CMIN, CMIN, CMAX, CMAX);
    send_seg(CMAX, CMAX, CMIN, CMIN);
    send_seg(CMIN, 0, CMIN, 0);
    random_phase(100);

    set_rect(EXT_MAX, 0);
    random_phase(100);
    set_rect(0, 0);
    random_phase(60);
    set_rect(256, 1024);
    random_phase(140);
    set_rect($urandom_range(0, EXT_MAX), $urandom_range(0, EXT_MAX));
    random_phase(100);
    set_rect($urandom_range(1, 1 << 16), $urandom_range(1, 1 << 16));
    random_phase(200);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
